@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds through reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/uyvy2rgb_pkg.sv @@
// Types and constants for the UYVY to RGB shift-add converter.
// No dependencies; imported by every module of the block.
package uyvy2rgb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned FmtW  = 2;

  localparam logic [FmtW-1:0]  FMT_RGB  = 2'd0;
  localparam logic [FmtW-1:0]  FMT_RGBA = 2'd1;
  localparam logic [FmtW-1:0]  FMT_BGRA = 2'd2;

  localparam logic [ByteW-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ByteW-1:0] ALPHA_NONE   = 8'h00;

  typedef struct packed {
    logic [ByteW-1:0] chroma_blue;
    logic [ByteW-1:0] luma_first;
    logic [ByteW-1:0] chroma_red;
    logic [ByteW-1:0] luma_second;
    logic             only_first;
  } in_item_t;

  // Per-channel chroma contribution, modulo 256.
  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } chroma_off_t;

  typedef struct packed {
    logic [ByteW-1:0] ch0;
    logic [ByteW-1:0] ch1;
    logic [ByteW-1:0] ch2;
  } pix_t;

endpackage

@@ rtl/core/uyvy2rgb_chroma.sv @@
// Chroma centering and shift-add coefficient terms shared by both pixels.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_chroma (
  input  logic [uyvy2rgb_pkg::ByteW-1:0] chroma_blue,
  input  logic [uyvy2rgb_pkg::ByteW-1:0] chroma_red,
  output uyvy2rgb_pkg::chroma_off_t      off
);
  import uyvy2rgb_pkg::*;

  logic signed [ByteW-1:0] u;
  logic signed [ByteW-1:0] v;
  logic signed [ByteW-1:0] g_u;
  logic signed [ByteW-1:0] g_v;

  // subtract 128: flip the top bit
  assign u = signed'({~chroma_blue[ByteW-1], chroma_blue[ByteW-2:0]});
  assign v = signed'({~chroma_red[ByteW-1],  chroma_red[ByteW-2:0]});

  assign g_u = (u >>> 2) + (u >>> 4) + (u >>> 5);
  assign g_v = (v >>> 1) + (v >>> 3) + (v >>> 4) + (v >>> 5);

  assign off.red   = unsigned'(v + (v >>> 2) + (v >>> 3) + (v >>> 5));
  assign off.green = unsigned'(ByteW'(-g_u - g_v));
  assign off.blue  = unsigned'(u + (u >>> 1) + (u >>> 2) + (u >>> 6));

endmodule

@@ rtl/core/uyvy2rgb_pixel.sv @@
// One output pixel: luma plus chroma terms, channel order and drop.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_pixel (
  input  logic [uyvy2rgb_pkg::ByteW-1:0] luma,
  input  uyvy2rgb_pkg::chroma_off_t      off,
  input  logic                           swap,
  input  logic                           drop,
  output uyvy2rgb_pkg::pix_t             pix
);
  import uyvy2rgb_pkg::*;

  logic [ByteW-1:0] r;
  logic [ByteW-1:0] g;
  logic [ByteW-1:0] b;

  assign r = luma + off.red;
  assign g = luma + off.green;
  assign b = luma + off.blue;

  always_comb begin
    if (drop) begin
      pix = '0;
    end else begin
      pix.ch0 = swap ? b : r;
      pix.ch1 = g;
      pix.ch2 = swap ? r : b;
    end
  end

endmodule

@@ rtl/core/uyvy_to_rgb_shift_add_top.sv @@
// Top level of the UYVY 4:2:2 to RGB/RGBA/BGRA shift-add converter.
// Depends on uyvy2rgb_pkg, uyvy2rgb_chroma and uyvy2rgb_pixel.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_stall   | U, Y0, V, Y1, only_first
//   out_    | output    | out_valid / out_stall | two pixels, alpha, second_valid
//   cfg_    | input     | cfg_valid / cfg_ready | output format (2 bits)
//
// Each request passes through the input register, then the result register.
// One request per cycle is accepted while out_stall stays low.
// in_stall rises only when both registers hold requests and out_stall is high.
// Synchronous active-low reset clears valids and sets the format to RGB.
// cfg_ready is always high.
module uyvy_to_rgb_shift_add_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [uyvy2rgb_pkg::ByteW-1:0] in_chroma_blue,
  input  logic [uyvy2rgb_pkg::ByteW-1:0] in_luma_first,
  input  logic [uyvy2rgb_pkg::ByteW-1:0] in_chroma_red,
  input  logic [uyvy2rgb_pkg::ByteW-1:0] in_luma_second,
  input  logic                           in_only_first,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_first_ch0,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_first_ch1,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_first_ch2,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_second_ch0,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_second_ch1,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_second_ch2,
  output logic [uyvy2rgb_pkg::ByteW-1:0] out_alpha_out,
  output logic                           out_second_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uyvy2rgb_pkg::FmtW-1:0]  cfg_data
);
  import uyvy2rgb_pkg::*;

  logic [FmtW-1:0]  format_r;
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic             out_valid_r;
  pix_t             first_r;
  pix_t             second_r;
  logic [ByteW-1:0] alpha_r;
  logic             second_valid_r;

  logic             out_adv;
  logic             s1_adv;
  chroma_off_t      off;
  pix_t             first_nxt;
  pix_t             second_nxt;
  logic [ByteW-1:0] alpha_nxt;
  logic             swap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_r <= FMT_RGB;
    end else if (cfg_valid && cfg_ready) begin
      format_r <= cfg_data;
    end
  end

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_item_r <= '{chroma_blue: in_chroma_blue, luma_first: in_luma_first,
                     chroma_red: in_chroma_red, luma_second: in_luma_second,
                     only_first: in_only_first};
    end
  end

  uyvy2rgb_chroma u_chroma (
    .chroma_blue (s1_item_r.chroma_blue),
    .chroma_red  (s1_item_r.chroma_red),
    .off         (off)
  );

  assign swap      = (format_r == FMT_BGRA);
  assign alpha_nxt = (format_r != FMT_RGB) ? ALPHA_OPAQUE : ALPHA_NONE;

  uyvy2rgb_pixel u_pix_first (
    .luma (s1_item_r.luma_first),
    .off  (off),
    .swap (swap),
    .drop (1'b0),
    .pix  (first_nxt)
  );

  uyvy2rgb_pixel u_pix_second (
    .luma (s1_item_r.luma_second),
    .off  (off),
    .swap (swap),
    .drop (s1_item_r.only_first),
    .pix  (second_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      first_r        <= first_nxt;
      second_r       <= second_nxt;
      alpha_r        <= alpha_nxt;
      second_valid_r <= !s1_item_r.only_first;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_ch0    = first_r.ch0;
  assign out_first_ch1    = first_r.ch1;
  assign out_first_ch2    = first_r.ch2;
  assign out_second_ch0   = second_r.ch0;
  assign out_second_ch1   = second_r.ch1;
  assign out_second_ch2   = second_r.ch2;
  assign out_alpha_out    = alpha_r;
  assign out_second_valid = second_valid_r;

endmodule

@@ rtl/core/uyvy2rgb_chk.sv @@
// Port-level checker for the UYVY to RGB converter, bound to the top level.
// Depends on assert_macros.svh and uyvy2rgb_pkg.
`include "assert_macros.svh"

module uyvy2rgb_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [uyvy2rgb_pkg::ByteW-1:0] out_first_ch0,
  input logic [uyvy2rgb_pkg::ByteW-1:0] out_second_ch0,
  input logic [uyvy2rgb_pkg::ByteW-1:0] out_second_ch1,
  input logic [uyvy2rgb_pkg::ByteW-1:0] out_second_ch2,
  input logic [uyvy2rgb_pkg::ByteW-1:0] out_alpha_out,
  input logic                           out_second_valid
);
  import uyvy2rgb_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "out_valid high after reset")

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_first_ch0) && $stable(out_second_valid), "stalled result changed")

  `ASSERT_CLK(a_drop_zero, out_valid && !out_second_valid |-> out_second_ch0 == '0 && out_second_ch1 == '0 && out_second_ch2 == '0, "dropped pixel not zero")

  `ASSERT_CLK(a_alpha_code, out_valid |-> out_alpha_out == ALPHA_NONE || out_alpha_out == ALPHA_OPAQUE, "alpha not 0 or 255")

  `ASSERT_CLK(a_no_stall_free, !out_valid |-> !in_stall, "input stalled with empty output")

endmodule

bind uyvy_to_rgb_shift_add_top uyvy2rgb_chk u_chk (.*);

@@ dv/uyvy_to_rgb_shift_add_top_test.sv @@
// Self-checking testbench for uyvy_to_rgb_shift_add_top: directed and random UYVY groups
// are converted by a local shift-add predictor and compared field by field with each result.
// Depends on uyvy2rgb_pkg and the converter RTL.
module uyvy_to_rgb_shift_add_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import uyvy2rgb_pkg::*;

  localparam logic [FmtW-1:0] FMT_SPARE    = 2'd3;
  localparam int unsigned     CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned     PHASE_GROUPS = 250;

  typedef struct {
    pix_t             first;
    pix_t             second;
    logic [ByteW-1:0] alpha;
    logic             second_valid;
  } pixel_pair_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [ByteW-1:0] in_chroma_blue;
  logic [ByteW-1:0] in_luma_first;
  logic [ByteW-1:0] in_chroma_red;
  logic [ByteW-1:0] in_luma_second;
  logic             in_only_first;
  logic             out_valid;
  logic             out_stall;
  logic [ByteW-1:0] out_first_ch0;
  logic [ByteW-1:0] out_first_ch1;
  logic [ByteW-1:0] out_first_ch2;
  logic [ByteW-1:0] out_second_ch0;
  logic [ByteW-1:0] out_second_ch1;
  logic [ByteW-1:0] out_second_ch2;
  logic [ByteW-1:0] out_alpha_out;
  logic             out_second_valid;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [FmtW-1:0]  cfg_data;

  pixel_pair_t      pending_pixels[$];
  logic [FmtW-1:0]  active_format;
  logic             calm;
  int unsigned      mismatch_count;
  int unsigned      cycle_count;

  uyvy_to_rgb_shift_add_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_chroma_blue   (in_chroma_blue),
    .in_luma_first    (in_luma_first),
    .in_chroma_red    (in_chroma_red),
    .in_luma_second   (in_luma_second),
    .in_only_first    (in_only_first),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_ch0    (out_first_ch0),
    .out_first_ch1    (out_first_ch1),
    .out_first_ch2    (out_first_ch2),
    .out_second_ch0   (out_second_ch0),
    .out_second_ch1   (out_second_ch1),
    .out_second_ch2   (out_second_ch2),
    .out_alpha_out    (out_alpha_out),
    .out_second_valid (out_second_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pix_t shade_pixel(input logic [ByteW-1:0] luma, input int u, input int v,
                                       input logic swap);
    int   red;
    int   green;
    int   blue;
    pix_t p;
    red   = luma + v + (v >>> 2) + (v >>> 3) + (v >>> 5);
    green = luma - ((u >>> 2) + (u >>> 4) + (u >>> 5))
                 - ((v >>> 1) + (v >>> 3) + (v >>> 4) + (v >>> 5));
    blue  = luma + u + (u >>> 1) + (u >>> 2) + (u >>> 6);
    p.ch0 = swap ? blue[7:0] : red[7:0];
    p.ch1 = green[7:0];
    p.ch2 = swap ? red[7:0] : blue[7:0];
    return p;
  endfunction

  function automatic pixel_pair_t convert_group(input in_item_t g);
    logic signed [ByteW-1:0] u_c;
    logic signed [ByteW-1:0] v_c;
    logic                    swap;
    pixel_pair_t             r;
    u_c   = g.chroma_blue ^ 8'h80;
    v_c   = g.chroma_red ^ 8'h80;
    swap  = (active_format == FMT_BGRA);
    r.first = shade_pixel(g.luma_first, int'(u_c), int'(v_c), swap);
    if (g.only_first) begin
      r.second = '0;
    end else begin
      r.second = shade_pixel(g.luma_second, int'(u_c), int'(v_c), swap);
    end
    r.alpha        = (active_format != FMT_RGB) ? ALPHA_OPAQUE : ALPHA_NONE;
    r.second_valid = ~g.only_first;
    return r;
  endfunction

  function automatic in_item_t make_group(input logic [ByteW-1:0] cb, input logic [ByteW-1:0] y0,
                                          input logic [ByteW-1:0] cr, input logic [ByteW-1:0] y1,
                                          input logic only);
    in_item_t g;
    g.chroma_blue = cb;
    g.luma_first  = y0;
    g.chroma_red  = cr;
    g.luma_second = y1;
    g.only_first  = only;
    return g;
  endfunction

  function automatic logic [ByteW-1:0] rand_byte();
    logic [ByteW-1:0] corners[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 99) < 20) begin
      return corners[$urandom_range(0, 6)];
    end
    return ByteW'($urandom);
  endfunction

  function automatic in_item_t rand_group();
    return make_group(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                      ($urandom_range(0, 3) == 0));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send_group(input in_item_t g);
    @(negedge clk);
    in_valid       = 1'b1;
    in_chroma_blue = g.chroma_blue;
    in_luma_first  = g.luma_first;
    in_chroma_red  = g.chroma_red;
    in_luma_second = g.luma_second;
    in_only_first  = g.only_first;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(convert_group(g));
  endtask

  task automatic idle_inputs();
    int unsigned n;
    n = 0;
    if (!calm && $urandom_range(0, 99) < 30) begin
      n = pick_len();
    end
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_format(input logic [FmtW-1:0] fmt);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = fmt;
    do @(posedge clk); while (!cfg_ready);
    active_format = fmt;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed_extremes();
    send_group(make_group(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    send_group(make_group(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_group(make_group(8'd128, 8'd0, 8'd128, 8'd255, 1'b0));
    send_group(make_group(8'd0, 8'd255, 8'd255, 8'd0, 1'b0));
    idle_inputs();
    send_group(make_group(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
    send_group(make_group(8'd128, 8'd128, 8'd128, 8'd128, 1'b1));
    send_group(make_group(8'd0, 8'd255, 8'd0, 8'd255, 1'b1));
    send_group(make_group(8'd255, 8'd0, 8'd255, 8'd0, 1'b1));
  endtask

  task automatic test_format_modes();
    logic [FmtW-1:0] modes[3] = '{FMT_RGBA, FMT_BGRA, FMT_SPARE};
    foreach (modes[i]) begin
      set_format(modes[i]);
      send_group(make_group(8'd0, 8'd255, 8'd255, 8'd0, 1'b0));
      send_group(make_group(8'd255, 8'd0, 8'd0, 8'd255, 1'b1));
      send_group(make_group(8'd1, 8'd254, 8'd127, 8'd129, 1'b0));
      send_group(rand_group());
    end
  endtask

  task automatic test_random_groups();
    logic [FmtW-1:0] plan[7];
    plan = '{FMT_BGRA, FMT_SPARE, FMT_RGB, FMT_RGBA, FmtW'($urandom), FmtW'($urandom),
             FmtW'($urandom)};
    foreach (plan[p]) begin
      set_format(plan[p]);
      calm = (p == 2) || (p == 5);
      repeat (PHASE_GROUPS) begin
        send_group(rand_group());
        idle_inputs();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    int unsigned stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        stall_left = ($urandom_range(0, 99) < 30) ? pick_len() : 0;
        out_stall  = (stall_left != 0);
        if (stall_left != 0) begin
          stall_left = stall_left - 1;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [ByteW-1:0] expv,
                                      input logic [ByteW-1:0] act);
    if (act !== expv) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, act);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_pair_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got first_ch0 %0h", $time,
                 out_first_ch0);
        mismatch_count++;
      end else begin
        e = pending_pixels.pop_front();
        check_field("first_ch0", e.first.ch0, out_first_ch0);
        check_field("first_ch1", e.first.ch1, out_first_ch1);
        check_field("first_ch2", e.first.ch2, out_first_ch2);
        check_field("second_ch0", e.second.ch0, out_second_ch0);
        check_field("second_ch1", e.second.ch1, out_second_ch1);
        check_field("second_ch2", e.second.ch2, out_second_ch2);
        check_field("alpha_out", e.alpha, out_alpha_out);
        check_field("second_valid", ByteW'(e.second_valid), ByteW'(out_second_valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_chroma_blue = '0;
    in_luma_first  = '0;
    in_chroma_red  = '0;
    in_luma_second = '0;
    in_only_first  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    active_format  = FMT_RGB;
    calm           = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    test_format_modes();
    test_random_groups();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/uyvy2rgb_pkg.sv
rtl/core/uyvy2rgb_chroma.sv
rtl/core/uyvy2rgb_pixel.sv
rtl/core/uyvy_to_rgb_shift_add_top.sv
rtl/core/uyvy2rgb_chk.sv
dv/uyvy_to_rgb_shift_add_top_test.sv
